// File: design/sbsd_pkg.sv
// Shared types, constants and helper functions for the spectral band shake detector.
// Has no dependencies; every other design file imports it.
`timescale 1ns / 1ps

package sbsd_pkg;

  localparam int BIN_COUNT  = 512;
  localparam int BIN_W      = 9;
  localparam int CNT_W      = 10;
  localparam int MAG_W      = 24;
  localparam int FREQ_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 72;

  localparam logic [BIN_W-1:0] BAND_LOW_RESET  = BIN_W'(10);
  localparam logic [BIN_W-1:0] BAND_HIGH_RESET = BIN_W'(25);
  localparam logic [MAG_W-1:0] THRESHOLD_RESET = MAG_W'(62915);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_LOW        = 2'd0,
    REG_BAND_HIGH       = 2'd1,
    REG_SHAKE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // One registered bin on its way into the accumulator.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
    logic             counted;
    logic             band_hit;
    logic [BIN_W-1:0] idx;
  } bin_item_t;

  // Result record; the first member sits in the highest bits, so shake lands in bit 0.
  typedef struct packed {
    logic [MAG_W-1:0]  band_max;
    logic [MAG_W-1:0]  peak_magnitude;
    logic [FREQ_W-1:0] peak_freq_q4;
    logic [BIN_W-1:0]  peak_bin;
    logic              shake;
  } result_t;

  // Band bounds are limited to the last bin of the spectrum.
  function automatic logic [BIN_W-1:0] clamp_bin(input logic [BIN_W-1:0] b);
    logic [CNT_W-1:0] wide;
    wide = {1'b0, b};
    if (wide > CNT_W'(BIN_COUNT - 1)) begin
      return BIN_W'(BIN_COUNT - 1);
    end
    return b;
  endfunction

  // Peak frequency in Hz with 4 fraction bits: bin * 12800 / 512 = bin * 25 = 16b + 8b + b.
  function automatic logic [FREQ_W-1:0] peak_freq(input logic [BIN_W-1:0] b);
    logic [FREQ_W-1:0] w;
    w = FREQ_W'(b);
    return (w << 4) + (w << 3) + w;
  endfunction

endpackage

// File: design/spectral_band_shake_detector.sv
// Top level of the spectral band shake detector: configuration registers and the
// two pipeline stages. Depends on sbsd_pkg, sbsd_bin_stage and sbsd_accum.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake          Payload
//  --------  ---------  -----------------  ------------------------------------------
//  s_*       in         s_tvalid/s_tready  s_tdata: bin_magnitude; s_tlast: last_bin
//  m_*       out        m_tvalid/m_tready  m_tdata: shake, peak_bin, peak_freq_q4,
//                                          peak_magnitude, band_max
//  cfg_*     in         cfg_valid/ready    cfg_index: register, cfg_data: value
//
//  One bin is taken in every cycle while s_tready is high. The input register takes a
//  bin at its transfer; the accumulator then compares it and, for the last bin, loads
//  the output register, which raises m_tvalid.
//  Reset (rst, synchronous) clears the frame state, the shake flag and both valid
//  flags, and loads the register defaults. There is no clearing pass.
//  A result waiting on m_tready stalls only the next last bin; ordinary bins keep
//  flowing into the running maxima, so s_tready drops only in that case.
//
module spectral_band_shake_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sbsd_pkg::TDATA_IN_W-1:0]   s_tdata,   // [23:0] bin_magnitude
  input  logic                              s_tlast,   // last_bin
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] shake, [9:1] peak_bin, [23:10] peak_freq_q4, [47:24] peak_magnitude,
  // [71:48] band_max
  output logic [sbsd_pkg::TDATA_OUT_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sbsd_pkg::*;

  logic [BIN_W-1:0] band_low_bin;
  logic [BIN_W-1:0] band_high_bin;
  logic [MAG_W-1:0] shake_threshold;

  logic      item_valid;
  bin_item_t item;
  logic      advance;

  // Register writes are always accepted; writes to unused indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low_bin    <= BAND_LOW_RESET;
      band_high_bin   <= BAND_HIGH_RESET;
      shake_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BAND_LOW:        band_low_bin    <= cfg_data[BIN_W-1:0];
        REG_BAND_HIGH:       band_high_bin   <= cfg_data[BIN_W-1:0];
        REG_SHAKE_THRESHOLD: shake_threshold <= cfg_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one numbers each bin and tags band membership with the bounds in force
  // at its transfer.
  sbsd_bin_stage u_bin_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .band_low   (band_low_bin),
    .band_high  (band_high_bin),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Stage two folds the bin into the running maxima and, on the last bin, makes the
  // hysteresis decision and loads the output register.
  sbsd_accum u_accum (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item            (item),
    .shake_threshold (shake_threshold),
    .advance         (advance),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

// File: design/sbsd_bin_stage.sv
// Input register of the shake detector: takes one bin per transfer, numbers it
// and tags whether it falls inside the configured band. Depends on sbsd_pkg.
`timescale 1ns / 1ps

module sbsd_bin_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sbsd_pkg::TDATA_IN_W-1:0] s_tdata,   // [23:0] bin_magnitude
  input  logic                          s_tlast,
  input  logic [sbsd_pkg::BIN_W-1:0]    band_low,
  input  logic [sbsd_pkg::BIN_W-1:0]    band_high,
  input  logic                          advance,
  output logic                          item_valid,
  output sbsd_pkg::bin_item_t           item
);
  import sbsd_pkg::*;

  logic [CNT_W-1:0] bin_counter;
  logic             take;
  logic             counting;
  logic [BIN_W-1:0] idx;
  logic [BIN_W-1:0] lo;
  logic [BIN_W-1:0] hi;

  assign s_tready = !item_valid || advance;
  assign take     = s_tvalid && s_tready;
  assign counting = bin_counter < CNT_W'(BIN_COUNT);
  assign idx      = bin_counter[BIN_W-1:0];
  assign lo       = clamp_bin(band_low);
  assign hi       = clamp_bin(band_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      bin_counter <= '0;
    end else begin
      if (take) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (take) begin
        if (s_tlast) begin
          bin_counter <= '0;
        end else if (counting) begin
          bin_counter <= bin_counter + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.mag      <= s_tdata[MAG_W-1:0];
      item.last     <= s_tlast;
      item.counted  <= counting;
      item.band_hit <= counting && (idx >= lo) && (idx <= hi);
      item.idx      <= idx;
    end
  end

  property p_counter_bounded;
    @(posedge clk) disable iff (rst) bin_counter <= CNT_W'(BIN_COUNT);
  endproperty
  a_counter_bounded: assert property (p_counter_bounded)
    else $error("bin counter ran past the spectrum length");

  property p_hit_needs_count;
    @(posedge clk) disable iff (rst) (item_valid && item.band_hit) |-> item.counted;
  endproperty
  a_hit_needs_count: assert property (p_hit_needs_count)
    else $error("band hit on a bin beyond the spectrum length");

  property p_last_restarts;
    @(posedge clk) disable iff (rst) (take && s_tlast) |=> (bin_counter == '0);
  endproperty
  a_last_restarts: assert property (p_last_restarts)
    else $error("bin counter did not restart after the last bin");

endmodule

// File: design/sbsd_accum.sv
// Running peak and band maximum, hysteresis decision and output register of the
// shake detector. Depends on sbsd_pkg.
`timescale 1ns / 1ps

module sbsd_accum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  sbsd_pkg::bin_item_t            item,
  input  logic [sbsd_pkg::MAG_W-1:0]     shake_threshold,
  output logic                           advance,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sbsd_pkg::TDATA_OUT_W-1:0] m_tdata
);
  import sbsd_pkg::*;

  logic [MAG_W-1:0] running_peak;
  logic [BIN_W-1:0] running_peak_bin;
  logic [MAG_W-1:0] running_band_max;
  logic             shaking_flag;
  result_t          result;

  logic [MAG_W-1:0] peak_next;
  logic [BIN_W-1:0] peak_bin_next;
  logic [MAG_W-1:0] band_max_next;
  logic             shake_now;
  logic             load_result;

  // A last bin needs the output slot; other bins only fold into the running state.
  assign advance     = item_valid && (!item.last || !m_tvalid || m_tready);
  assign load_result = advance && item.last;

  always_comb begin
    peak_next     = running_peak;
    peak_bin_next = running_peak_bin;
    band_max_next = running_band_max;
    if (item.counted && (item.mag > running_peak)) begin
      peak_next     = item.mag;
      peak_bin_next = item.idx;
    end
    if (item.band_hit && (item.mag > running_band_max)) begin
      band_max_next = item.mag;
    end
    // While shaking, the exit level is half the threshold, compared as twice the band max.
    if (shaking_flag) begin
      shake_now = {band_max_next, 1'b0} >= {1'b0, shake_threshold};
    end else begin
      shake_now = band_max_next >= shake_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid         <= 1'b0;
      shaking_flag     <= 1'b0;
      running_peak     <= '0;
      running_peak_bin <= '0;
      running_band_max <= '0;
    end else begin
      if (load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance) begin
        if (item.last) begin
          shaking_flag     <= shake_now;
          running_peak     <= '0;
          running_peak_bin <= '0;
          running_band_max <= '0;
        end else begin
          running_peak     <= peak_next;
          running_peak_bin <= peak_bin_next;
          running_band_max <= band_max_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.shake          <= shake_now;
      result.peak_bin       <= peak_bin_next;
      result.peak_freq_q4   <= peak_freq(peak_bin_next);
      result.peak_magnitude <= peak_next;
      result.band_max       <= band_max_next;
    end
  end

  assign m_tdata = result;

  property p_frame_cleared;
    @(posedge clk) disable iff (rst)
      load_result |=> (running_peak == '0 && running_peak_bin == '0 &&
                       running_band_max == '0);
  endproperty
  a_frame_cleared: assert property (p_frame_cleared)
    else $error("frame state not cleared after a result");

  property p_band_below_peak;
    @(posedge clk) disable iff (rst) running_band_max <= running_peak;
  endproperty
  a_band_below_peak: assert property (p_band_below_peak)
    else $error("band maximum exceeds global peak");

  property p_result_consistent;
    @(posedge clk) disable iff (rst)
      m_tvalid |-> (result.band_max <= result.peak_magnitude &&
                    result.peak_freq_q4 == peak_freq(result.peak_bin));
  endproperty
  a_result_consistent: assert property (p_result_consistent)
    else $error("result record is inconsistent");

endmodule

// File: tb/tb_spectral_band_shake_detector.sv
// Self-checking testbench for spectral_band_shake_detector: streams spectrum bins with
// random idling, predicts each frame result and compares it field by field.
// Depends on sbsd_pkg and the design files of the block.
`timescale 1ns / 1ps

module tb_spectral_band_shake_detector;
  import sbsd_pkg::*;

  // Run shape. The stimulus stops once the item target is met.
  localparam int ITEM_TARGET   = 850;
  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver hold-off below.
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 300;
  // Settle after the last result so that no bin is still in the input register
  // when a register is written.
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {SINK_OPEN, SINK_SPARSE, SINK_COIN, SINK_PULSE} sink_mode_t;

  // One row of the directed table. Rows with typed set carry a result that can
  // be read straight off the spec; all other rows rely on the predictor.
  typedef struct {
    int               phase;
    logic [MAG_W-1:0] mag;
    logic             last;
    bit               typed;
    result_t          want;
  } bin_row_t;

  typedef struct {
    logic [BIN_W-1:0] lo;
    logic [BIN_W-1:0] hi;
    logic [MAG_W-1:0] thr;
  } band_setting_t;

  localparam result_t NO_REPORT = '0;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Shadow of the configuration registers, updated on each config transfer.
  logic [BIN_W-1:0] band_lo   = BAND_LOW_RESET;
  logic [BIN_W-1:0] band_hi   = BAND_HIGH_RESET;
  logic [MAG_W-1:0] threshold = THRESHOLD_RESET;

  // Frame accumulation as the block should see it.
  int               bins_taken  = 0;
  logic [MAG_W-1:0] top_mag     = '0;
  int               top_bin     = 0;
  logic [MAG_W-1:0] band_top    = '0;
  logic             shaking_now = 1'b0;

  result_t          pending_reports[$];
  int               bins_sent = 0;
  int               errors = 0;

  // Sender idling: bursts of random length separated by random gaps.
  bit               gaps_on = 1'b1;
  int               burst_left = 0;
  logic [MAG_W-1:0] prev_mag = '0;

  // The stimulus bumps this counter to ask the receiver for one long hold-off.
  int               hold_requests = 0;

  spectral_band_shake_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t make_report(input bit shake, input int bin, input int freq,
                                          input int mag, input int band);
    result_t r;
    r.shake          = shake;
    r.peak_bin       = BIN_W'(bin);
    r.peak_freq_q4   = FREQ_W'(freq);
    r.peak_magnitude = MAG_W'(mag);
    r.band_max       = MAG_W'(band);
    return r;
  endfunction

  // Folds one accepted bin into the frame state and, on the last bin, queues
  // the frame result. Bins past the spectrum length only count for the last
  // marker. The shake decision uses the full threshold when calm and half of
  // it (as twice the band maximum) while shaking.
  task automatic account_bin(input logic [MAG_W-1:0] mag, input logic last,
                             input bit typed, input result_t typed_rep);
    int      lo;
    int      hi;
    result_t rep;
    lo = (int'(band_lo) > BIN_COUNT - 1) ? BIN_COUNT - 1 : int'(band_lo);
    hi = (int'(band_hi) > BIN_COUNT - 1) ? BIN_COUNT - 1 : int'(band_hi);
    if (bins_taken < BIN_COUNT) begin
      if (mag > top_mag) begin
        top_mag = mag;
        top_bin = bins_taken;
      end
      if (bins_taken >= lo && bins_taken <= hi && mag > band_top) begin
        band_top = mag;
      end
      bins_taken++;
    end
    if (last) begin
      if (shaking_now) begin
        rep.shake = ({band_top, 1'b0} >= {1'b0, threshold});
      end else begin
        rep.shake = (band_top >= threshold);
      end
      rep.peak_bin       = BIN_W'(top_bin);
      rep.peak_freq_q4   = FREQ_W'((top_bin * 12800) / BIN_COUNT);
      rep.peak_magnitude = top_mag;
      rep.band_max       = band_top;
      pending_reports.push_back(typed ? typed_rep : rep);
      shaking_now = rep.shake;
      bins_taken  = 0;
      top_mag     = '0;
      top_bin     = 0;
      band_top    = '0;
    end
  endtask

  // Offers one bin, honoring the burst and gap pattern, and accounts for it at
  // the edge where the transfer happens.
  task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last,
                          input bit typed, input result_t typed_rep);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= TDATA_IN_W'($urandom);
        s_tlast  <= 1'($urandom_range(0, 1));
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= mag;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    account_bin(mag, last, typed, typed_rep);
    bins_sent++;
  endtask

  task automatic cfg_write(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (which)
      REG_BAND_LOW:        band_lo   = value[BIN_W-1:0];
      REG_BAND_HIGH:       band_hi   = value[BIN_W-1:0];
      REG_SHAKE_THRESHOLD: threshold = value[MAG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= CFG_DATA_W'($urandom);
  endtask

  // Stops offering bins, waits for every queued result and lets the pipeline
  // settle so that a register write cannot race a bin still in flight.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Picks a new band and threshold, extremes included, and writes a random
  // subset of the registers. Band writes carry junk above bit 8.
  task automatic retune();
    logic [BIN_W-1:0] lo;
    logic [BIN_W-1:0] hi;
    logic [MAG_W-1:0] thr;
    case ($urandom_range(0, 9))
      0: begin lo = '0; hi = '1; end
      1: begin lo = '1; hi = '1; end
      2: begin lo = '0; hi = '0; end
      3: begin lo = '1; hi = '0; end
      default: begin
        lo = BIN_W'($urandom_range(0, 24));
        hi = BIN_W'($urandom_range(0, 32));
      end
    endcase
    case ($urandom_range(0, 5))
      0: thr = '0;
      1: thr = '1;
      2: thr = MAG_W'($urandom);
      default: thr = MAG_W'($urandom_range(1, 'h3FFFF));
    endcase
    if ($urandom_range(0, 3) != 0) cfg_write(REG_BAND_LOW, {15'($urandom), lo});
    if ($urandom_range(0, 3) != 0) cfg_write(REG_BAND_HIGH, {15'($urandom), hi});
    if ($urandom_range(0, 3) != 0) cfg_write(REG_SHAKE_THRESHOLD, thr);
  endtask

  // Magnitudes cluster around the threshold and its half so that the
  // hysteresis compare is hit on both sides; repeats create peak ties.
  function automatic logic [MAG_W-1:0] pick_magnitude();
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 'hFFFFFF;
      2, 3: v = int'($urandom_range(0, 'hFFFFFF));
      4: v = int'(threshold) + int'($urandom_range(0, 4)) - 2;
      5: v = int'(threshold >> 1) + int'($urandom_range(0, 2)) - 1;
      6: v = int'(prev_mag);
      default: v = int'($urandom_range(0, 'hFFFF));
    endcase
    if (v < 0) v = 0;
    if (v > 'hFFFFFF) v = 'hFFFFFF;
    prev_mag = MAG_W'(v);
    return prev_mag;
  endfunction

  // Sends one frame. Now and then the frame is cut in two, the block is left
  // to drain and the registers change before the rest of the frame arrives.
  task automatic send_frame(input int len, input bit may_split);
    int split;
    split = (may_split && len >= 2 && $urandom_range(0, 5) == 0) ?
            $urandom_range(1, len - 1) : 0;
    for (int i = 0; i < len; i++) begin
      if (split != 0 && i == split) begin
        wait_idle();
        retune();
      end
      send_bin(pick_magnitude(), i == len - 1, 1'b0, NO_REPORT);
    end
  endtask

  task automatic check_field(input string name, input logic [MAG_W-1:0] want,
                             input logic [MAG_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Every result transfer is checked against the oldest predicted frame.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_tdata);
      end else begin
        want = pending_reports.pop_front();
        check_field("shake", MAG_W'(want.shake), MAG_W'(got.shake));
        check_field("peak_bin", MAG_W'(want.peak_bin), MAG_W'(got.peak_bin));
        check_field("peak_freq_q4", MAG_W'(want.peak_freq_q4), MAG_W'(got.peak_freq_q4));
        check_field("peak_magnitude", want.peak_magnitude, got.peak_magnitude);
        check_field("band_max", want.band_max, got.band_max);
      end
    end
  end

  // Receiver: switches between stall patterns at random intervals, and on
  // request holds off for a long stretch so that results back up into the
  // block and its input stalls.
  initial begin : report_sink
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    int         holds_served;
    int         tick;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    holds_served = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   m_tready <= 1'b1;
          SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
          default:     m_tready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Ends a hung run: counts cycles in which no transfer of any kind happens.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    bin_row_t      dir_rows[16];
    band_setting_t dir_settings[3];
    int            cur_phase;

    // Phase 0 runs on the reset values; phase 1 uses a two-bin band just past
    // bin zero; phase 2 has an empty band and a zero threshold.
    dir_settings = '{
      '{BAND_LOW_RESET, BAND_HIGH_RESET, THRESHOLD_RESET},
      '{BIN_W'(1),   BIN_W'(2), MAG_W'(256)},
      '{BIN_W'(300), BIN_W'(2), MAG_W'(0)}
    };

    dir_rows = '{
      // All bins zero: nothing beats the cleared peak, result is all zero.
      '{0, 24'h000000, 1'b1, 1'b1, make_report(0, 0, 0, 'h000000, 'h000000)},
      // Largest magnitude, outside the default band.
      '{0, 24'hFFFFFF, 1'b1, 1'b1, make_report(0, 0, 0, 'hFFFFFF, 'h000000)},
      // First maximum wins: the repeat of 300 in bin 2 does not move the peak.
      '{1, 24'h000005, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'h00012C, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'h00012C, 1'b1, 1'b1, make_report(1, 1, 25, 'h00012C, 'h00012C)},
      // Shaking: twice the band max equals the threshold exactly, still shaking.
      '{1, 24'h000000, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'h000080, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'h000000, 1'b1, 1'b1, make_report(1, 1, 25, 'h000080, 'h000080)},
      // One below half the threshold drops out of shaking.
      '{1, 24'h000000, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'h00007F, 1'b1, 1'b1, make_report(0, 1, 25, 'h00007F, 'h00007F)},
      // Calm again: the full threshold applies, so 255 is not enough.
      '{1, 24'h000000, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'h0000FF, 1'b1, 1'b1, make_report(0, 1, 25, 'h0000FF, 'h0000FF)},
      // Full scale everywhere: peak stays on bin 0, band max saturates.
      '{1, 24'hFFFFFF, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'hFFFFFF, 1'b0, 1'b0, NO_REPORT},
      '{1, 24'hFFFFFF, 1'b1, 1'b1, make_report(1, 0, 0, 'hFFFFFF, 'hFFFFFF)},
      // Empty band gives zero; a zero threshold keeps the flag set.
      '{2, 24'h000007, 1'b1, 1'b1, make_report(1, 0, 0, 'h000007, 'h000000)}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_phase = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].phase != cur_phase) begin
        cur_phase = dir_rows[i].phase;
        wait_idle();
        cfg_write(REG_BAND_LOW, {15'd0, dir_settings[cur_phase].lo});
        cfg_write(REG_BAND_HIGH, {15'd0, dir_settings[cur_phase].hi});
        cfg_write(REG_SHAKE_THRESHOLD, dir_settings[cur_phase].thr);
      end
      send_bin(dir_rows[i].mag, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end

    // One oversized frame: the band sits at the top of the spectrum, and the
    // two full-scale bins past the end must not touch peak or band.
    wait_idle();
    cfg_write(REG_BAND_LOW, {15'd0, BIN_W'(500)});
    cfg_write(REG_BAND_HIGH, {15'd0, BIN_W'(BIN_COUNT - 1)});
    cfg_write(REG_SHAKE_THRESHOLD, MAG_W'($urandom));
    for (int i = 0; i < BIN_COUNT + 2; i++) begin
      send_bin((i >= BIN_COUNT) ? MAG_W'('hFFFFFF) : pick_magnitude(),
               i == BIN_COUNT + 1, 1'b0, NO_REPORT);
    end

    // Back pressure: short frames at full rate while the receiver holds off,
    // so finished frames pile up and the block refuses the next last bin.
    wait_idle();
    retune();
    gaps_on = 1'b0;
    hold_requests++;
    repeat (40) send_frame($urandom_range(1, 2), 1'b0);

    // Random phases: new settings, a few frames of mostly small length, with
    // or without sender gaps.
    while (bins_sent < ITEM_TARGET) begin
      wait_idle();
      retune();
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 6)) begin
        send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(17, 48) :
                   $urandom_range(1, 16), 1'b1);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
